[sv/mbet_pkg.sv]
// Shared types and constants for the Mandelbrot escape-time engine.
// No dependencies; every other file imports this package.
`default_nettype none

package mbet_pkg;

	localparam int MAX_DIM   = 1024;
	localparam int FRAC_BITS = 28;

	localparam int DIM_W     = $clog2(MAX_DIM);
	localparam int GRID_W    = DIM_W + 1;
	localparam int Z_W       = 32;
	localparam int STEP_W    = 31;
	localparam int ITER_W    = 16;
	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 3;
	localparam int PROD_W    = GRID_W + STEP_W + 1;
	localparam int C_W       = PROD_W + 1;
	localparam int P_W       = 2 * Z_W;
	localparam int MAG_SH    = 2 * FRAC_BITS + 2;

	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_REAL = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_IMAG = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 3'd5;

	localparam logic [STEP_W-1:0] RST_STEP_SIZE   = 31'd1048576;
	localparam logic [ITER_W-1:0] RST_MAX_ITER    = 16'd256;
	localparam logic [GRID_W-1:0] RST_GRID_WIDTH  = 11'd256;
	localparam logic [GRID_W-1:0] RST_GRID_HEIGHT = 11'd256;

	typedef struct packed {
		logic signed [Z_W-1:0] origin_real;
		logic signed [Z_W-1:0] origin_imag;
		logic [STEP_W-1:0]     step_size;
		logic [ITER_W-1:0]     max_iterations;
		logic [GRID_W-1:0]     grid_width;
		logic [GRID_W-1:0]     grid_height;
	} cfg_t;

	typedef enum logic [1:0] {
		RES_ZERO,
		RES_ROUND,
		RES_NEXT
	} res_sel_t;

	typedef struct packed {
		logic     load;
		logic     prod;
		logic     orig;
		logic     upd;
		logic     mul;
		logic     finish;
		res_sel_t res_sel;
	} cmd_t;

	typedef struct packed {
		logic mag_esc;
		logic fits;
		logic at_limit;
	} stat_t;

endpackage

`default_nettype wire

[sv/mbet_regs.sv]
// Configuration register file of the escape-time engine.
// Depends on mbet_pkg for register indexes, reset values and cfg_t.
`default_nettype none

module mbet_regs import mbet_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_write,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	output cfg_t                      cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin_real    <= '0;
			cfg_q.origin_imag    <= '0;
			cfg_q.step_size      <= RST_STEP_SIZE;
			cfg_q.max_iterations <= RST_MAX_ITER;
			cfg_q.grid_width     <= RST_GRID_WIDTH;
			cfg_q.grid_height    <= RST_GRID_HEIGHT;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_ORIGIN_REAL: cfg_q.origin_real    <= $signed(cfg_data[Z_W-1:0]);
				REG_ORIGIN_IMAG: cfg_q.origin_imag    <= $signed(cfg_data[Z_W-1:0]);
				REG_STEP_SIZE:   cfg_q.step_size      <= cfg_data[STEP_W-1:0];
				REG_MAX_ITER:    cfg_q.max_iterations <= cfg_data[ITER_W-1:0];
				REG_GRID_WIDTH:  cfg_q.grid_width     <= cfg_data[GRID_W-1:0];
				REG_GRID_HEIGHT: cfg_q.grid_height    <= cfg_data[GRID_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

[sv/mbet_dp.sv]
// Datapath of the escape-time engine: point setup, z update, squares, round count.
// Depends on mbet_pkg; driven by mbet_ctrl through cmd_t, reports through stat_t.
`default_nettype none

module mbet_dp import mbet_pkg::*; (
	input  wire logic             clk,
	input  wire cfg_t             cfg,
	input  wire cmd_t             cmd,
	input  wire logic [DIM_W-1:0] pixel_row,
	input  wire logic [DIM_W-1:0] pixel_col,
	output stat_t                 stat,
	output logic [ITER_W-1:0]     escape_count
);

	logic signed [GRID_W-1:0] dcol_q, drow_q;
	logic signed [PROD_W-1:0] pre_q, pim_q;
	logic signed [Z_W-1:0]    c_re_q, c_im_q, z0_q, z1_q;
	logic                     c_ovf_q;
	logic signed [P_W-1:0]    sq0_q, sq1_q, cr_q;
	logic [ITER_W-1:0]        k_q;
	logic [ITER_W-1:0]        escape_count_q;

	logic signed [C_W-1:0] cre_w, cim_w;
	logic                  cre_fit, cim_fit;
	logic signed [P_W-1:0] diff, sh0, sh1, n0, n1;
	logic                  n0_fit, n1_fit;
	logic [P_W-1:0]        mag;
	logic [ITER_W-1:0]     res;

	// point setup: centre offsets, then products, then origin add
	assign cre_w = $signed({{(C_W-Z_W){cfg.origin_real[Z_W-1]}}, cfg.origin_real})
		+ $signed({pre_q[PROD_W-1], pre_q});
	assign cim_w = $signed({{(C_W-Z_W){cfg.origin_imag[Z_W-1]}}, cfg.origin_imag})
		+ $signed({pim_q[PROD_W-1], pim_q});
	assign cre_fit = (&cre_w[C_W-1:Z_W-1]) || (~|cre_w[C_W-1:Z_W-1]);
	assign cim_fit = (&cim_w[C_W-1:Z_W-1]) || (~|cim_w[C_W-1:Z_W-1]);

	// round update from the registered squares and cross product
	assign diff = sq0_q - sq1_q;
	assign sh0  = diff >>> FRAC_BITS;
	assign sh1  = cr_q >>> (FRAC_BITS - 1);
	assign n0   = $signed({{(P_W-Z_W){c_re_q[Z_W-1]}}, c_re_q}) + sh0;
	assign n1   = $signed({{(P_W-Z_W){c_im_q[Z_W-1]}}, c_im_q}) + sh1;
	assign n0_fit = (&n0[P_W-1:Z_W-1]) || (~|n0[P_W-1:Z_W-1]);
	assign n1_fit = (&n1[P_W-1:Z_W-1]) || (~|n1[P_W-1:Z_W-1]);

	// squares of the current z are both the escape test and next round's input
	assign mag = $unsigned(sq0_q) + $unsigned(sq1_q);

	assign stat.mag_esc  = |mag[P_W-1:MAG_SH];
	assign stat.fits     = n0_fit && n1_fit && !c_ovf_q;
	assign stat.at_limit = (k_q == cfg.max_iterations);

	always_comb begin
		unique case (cmd.res_sel)
			RES_ZERO:  res = '0;
			RES_ROUND: res = k_q;
			RES_NEXT:  res = k_q + ITER_W'(1);
			default:   res = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dcol_q <= $signed({1'b0, pixel_col}) - $signed({1'b0, cfg.grid_width[GRID_W-1:1]});
			drow_q <= $signed({1'b0, cfg.grid_height[GRID_W-1:1]}) - $signed({1'b0, pixel_row});
		end
		if (cmd.prod) begin
			pre_q <= dcol_q * $signed({1'b0, cfg.step_size});
			pim_q <= drow_q * $signed({1'b0, cfg.step_size});
		end
		if (cmd.orig) begin
			c_re_q  <= cre_w[Z_W-1:0];
			c_im_q  <= cim_w[Z_W-1:0];
			c_ovf_q <= !cre_fit || !cim_fit;
			z0_q    <= '0;
			z1_q    <= '0;
			sq0_q   <= '0;
			sq1_q   <= '0;
			cr_q    <= '0;
			k_q     <= '0;
		end
		if (cmd.upd) begin
			z0_q <= n0[Z_W-1:0];
			z1_q <= n1[Z_W-1:0];
		end
		if (cmd.mul) begin
			sq0_q <= z0_q * z0_q;
			sq1_q <= z1_q * z1_q;
			cr_q  <= z0_q * z1_q;
			k_q   <= k_q + ITER_W'(1);
		end
		if (cmd.finish)
			escape_count_q <= res;
	end

	assign escape_count = escape_count_q;

endmodule

`default_nettype wire

[sv/mbet_ctrl.sv]
// Controller of the escape-time engine: sequences setup and rounds, owns the handshakes.
// Depends on mbet_pkg for cmd_t, stat_t and res_sel_t.
`default_nettype none

module mbet_ctrl import mbet_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  wire logic  out_ready,
	input  wire stat_t stat,
	output cmd_t       cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_PROD,
		S_ORIG,
		S_ITER,
		S_MUL
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   fin, room;

	assign fin  = stat.mag_esc || stat.at_limit || !stat.fits;
	assign room = !out_valid_q || out_ready;

	always_comb begin
		cmd         = '0;
		cmd.res_sel = RES_ZERO;
		state_d     = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_PROD;
				end
			end
			S_PROD: begin
				cmd.prod = 1'b1;
				state_d  = S_ORIG;
			end
			S_ORIG: begin
				cmd.orig = 1'b1;
				state_d  = S_ITER;
			end
			S_ITER: begin
				priority if (stat.mag_esc)
					cmd.res_sel = RES_ROUND;
				else if (stat.at_limit)
					cmd.res_sel = RES_ZERO;
				else
					cmd.res_sel = RES_NEXT;
				// hold here while the previous result is still waiting
				if (fin && room) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end else if (!fin) begin
					cmd.upd = 1'b1;
					state_d = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_ITER;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_PROD))
		else $error("accepted request did not start setup");

	a_finish_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!out_valid_q || out_ready))
		else $error("result written over an untaken result");

	a_finish_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> out_valid_q)
		else $error("finished result not presented");

	a_mul_after_upd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MUL) |-> $past(cmd.upd))
		else $error("squares taken without a z update");

endmodule

`default_nettype wire

[sv/mandelbrot_escape_time_top.sv]
// Top level of the Mandelbrot escape-time engine: config regs, controller, datapath.
// Depends on mbet_pkg, mbet_regs, mbet_ctrl and mbet_dp.
//
//   channel  direction  handshake               payload
//   in       input      in_valid / in_ready     pixel_row, pixel_col
//   out      output     out_valid / out_ready   escape_count
//   cfg      input      cfg_write               cfg_index, cfg_data
//
// One pixel at a time: a request is not taken until the previous pixel's rounds are done.
// Each round of the loop: three 32x32 products in one cycle, then the z add
// and escape compare in the next.
// A finished result sits in an output register; the next request is taken meanwhile.
// Reset restores the register defaults; no clearing pass.
`default_nettype none

module mandelbrot_escape_time_top import mbet_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [DIM_W-1:0]     pixel_row,
	input  wire logic [DIM_W-1:0]     pixel_col,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [ITER_W-1:0]         escape_count,
	input  wire logic                 cfg_write,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data
);

	cfg_t  cfg;
	cmd_t  cmd;
	stat_t stat;

	mbet_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	mbet_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	mbet_dp u_dp (
		.clk          (clk),
		.cfg          (cfg),
		.cmd          (cmd),
		.pixel_row    (pixel_row),
		.pixel_col    (pixel_col),
		.stat         (stat),
		.escape_count (escape_count)
	);

endmodule

`default_nettype wire

[tb/sv/tb.sv]
// Testbench for the Mandelbrot escape-time engine. It predicts each pixel's escape
// round in software and checks every result in order.
// Depends on mbet_pkg and mandelbrot_escape_time_top.
`default_nettype none

module tb;
	import mbet_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
	localparam int     Q_ONE            = 1 << FRAC_BITS;
	localparam int     FRAMES           = 7;
	localparam int     PIXELS_PER_FRAME = 105;
	localparam longint RUN_LIMIT        = 72_000_000;

	typedef struct {
		logic [DIM_W-1:0]  row;
		logic [DIM_W-1:0]  col;
		logic [ITER_W-1:0] rounds;
	} escape_expect_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [DIM_W-1:0]     pixel_row = '0;
	logic [DIM_W-1:0]     pixel_col = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [ITER_W-1:0]    escape_count;
	logic                 cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	escape_expect_t pending_escapes[$];
	cfg_t           model_cfg;
	int             mismatch_count = 0;
	bit             gaps_on = 1'b1;
	bit             stalls_on = 1'b1;

	mandelbrot_escape_time_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.pixel_row    (pixel_row),
		.pixel_col    (pixel_col),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.escape_count (escape_count),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Escape round of one pixel under the given register set; 0 if it stays bounded.
	function automatic logic [ITER_W-1:0] escape_round(input cfg_t c,
			input logic [DIM_W-1:0] row, input logic [DIM_W-1:0] col);
		longint c_re, c_im, z_re, z_im, n_re, n_im;
		longint unsigned mag;
		int k;
		c_re = longint'($signed(c.origin_real)) +
			(longint'(col) - longint'(c.grid_width >> 1)) * longint'(c.step_size);
		c_im = longint'($signed(c.origin_imag)) +
			(longint'(c.grid_height >> 1) - longint'(row)) * longint'(c.step_size);
		z_re = 0;
		z_im = 0;
		for (k = 0; k < int'(c.max_iterations); k++) begin
			n_re = c_re + ((z_re * z_re - z_im * z_im) >>> FRAC_BITS);
			n_im = c_im + ((z_re * z_im) >>> (FRAC_BITS - 1));
			// leaving the 32-bit range counts as an escape
			if (n_re < -64'sd2147483648 || n_re > 64'sd2147483647 ||
					n_im < -64'sd2147483648 || n_im > 64'sd2147483647)
				return ITER_W'(k + 1);
			mag = $unsigned(n_re * n_re) + $unsigned(n_im * n_im);
			if (mag >= (64'd1 << (2 * FRAC_BITS + 2)))
				return ITER_W'(k + 1);
			z_re = n_re;
			z_im = n_im;
		end
		return '0;
	endfunction

	task automatic report_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= 40)
			$display("[%0t] mismatch: %s", $time, what);
	endtask

	// Enter at a falling edge; returns at a falling edge with valid still high.
	task automatic send_pixel(input logic [DIM_W-1:0] row, input logic [DIM_W-1:0] col);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		in_valid  <= 1'b1;
		pixel_row <= row;
		pixel_col <= col;
		@(posedge clk);
		while (in_ready !== 1'b1) @(posedge clk);
		pending_escapes.push_back('{row, col, escape_round(model_cfg, row, col)});
		@(negedge clk);
	endtask

	// Drop valid and hold until every pending result is back.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_escapes.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		cfg_write <= 1'b0;
		@(negedge clk);
		case (idx)
			REG_ORIGIN_REAL: model_cfg.origin_real = value;
			REG_ORIGIN_IMAG: model_cfg.origin_imag = value;
			REG_STEP_SIZE:   model_cfg.step_size = value[STEP_W-1:0];
			REG_MAX_ITER:    model_cfg.max_iterations = value[ITER_W-1:0];
			REG_GRID_WIDTH:  model_cfg.grid_width = value[GRID_W-1:0];
			REG_GRID_HEIGHT: model_cfg.grid_height = value[GRID_W-1:0];
			default: ;
		endcase
	endtask

	task automatic load_config(input cfg_t c);
		wait_drained();
		write_reg(REG_ORIGIN_REAL, CFG_W'(c.origin_real));
		write_reg(REG_ORIGIN_IMAG, CFG_W'(c.origin_imag));
		write_reg(REG_STEP_SIZE, CFG_W'(c.step_size));
		write_reg(REG_MAX_ITER, CFG_W'(c.max_iterations));
		write_reg(REG_GRID_WIDTH, CFG_W'(c.grid_width));
		write_reg(REG_GRID_HEIGHT, CFG_W'(c.grid_height));
	endtask

	// Raw words with junk in the unused upper bits; keep the round limit short.
	task automatic write_random_regs();
		wait_drained();
		write_reg(REG_ORIGIN_REAL, $urandom());
		write_reg(REG_ORIGIN_IMAG, $urandom());
		write_reg(REG_STEP_SIZE, $urandom());
		write_reg(REG_MAX_ITER, {16'($urandom()), 16'($urandom_range(0, 300))});
		write_reg(REG_GRID_WIDTH, $urandom());
		write_reg(REG_GRID_HEIGHT, $urandom());
	endtask

	task automatic test_reset_defaults();
		send_pixel(10'd0, 10'd0);
		send_pixel(10'd128, 10'd128);
		send_pixel(10'd1023, 10'd1023);
		send_pixel(10'd0, 10'd1023);
		send_pixel(10'd1023, 10'd0);
	endtask

	task automatic test_zero_round_limit();
		load_config('{origin_real: 0, origin_imag: 0, step_size: RST_STEP_SIZE,
			max_iterations: 16'd0, grid_width: 11'd256, grid_height: 11'd256});
		send_pixel(10'd128, 10'd128);
		send_pixel(10'd0, 10'd0);
	endtask

	// c beyond the signed 32-bit range: real axis on either side, imaginary axis above
	task automatic test_overflow_escape();
		load_config('{origin_real: 32'sh7FFFFFFF, origin_imag: 0, step_size: 31'h7FFFFFFF,
			max_iterations: 16'd8, grid_width: 11'd2, grid_height: 11'd2});
		send_pixel(10'd1, 10'd1);
		send_pixel(10'd1, 10'd1023);
		load_config('{origin_real: 32'sh80000000, origin_imag: 32'sh7FFFFFFF,
			step_size: 31'h7FFFFFFF, max_iterations: 16'd8,
			grid_width: 11'd2047, grid_height: 11'd2047});
		send_pixel(10'd0, 10'd0);
		send_pixel(10'd0, 10'd1023);
	endtask

	// zero and oversized grids, pixels outside the grid, zero pitch
	task automatic test_grid_edges();
		load_config('{origin_real: 0, origin_imag: 0, step_size: RST_STEP_SIZE,
			max_iterations: 16'd32, grid_width: 11'd0, grid_height: 11'd0});
		send_pixel(10'd0, 10'd0);
		send_pixel(10'd1023, 10'd1023);
		send_pixel(10'd5, 10'd2);
		load_config('{origin_real: Q_ONE / 4, origin_imag: Q_ONE / 2, step_size: 31'd0,
			max_iterations: 16'd64, grid_width: 11'd2047, grid_height: 11'd2047});
		send_pixel(10'd1023, 10'd0);
		send_pixel(10'd0, 10'd1023);
	endtask

	// bounded orbits at the largest round limit: c = -1 and the cusp c = 0.25
	task automatic test_long_orbit();
		load_config('{origin_real: -Q_ONE, origin_imag: 0, step_size: 31'(Q_ONE >> 8),
			max_iterations: 16'hFFFF, grid_width: 11'd256, grid_height: 11'd256});
		send_pixel(10'd128, 10'd128);
		send_pixel(10'd128, 10'd448);
	endtask

	task automatic test_unused_index();
		load_config('{origin_real: -(Q_ONE / 2), origin_imag: Q_ONE / 4,
			step_size: RST_STEP_SIZE, max_iterations: RST_MAX_ITER,
			grid_width: RST_GRID_WIDTH, grid_height: RST_GRID_HEIGHT});
		write_reg(REG_SPARE_LO, $urandom());
		write_reg(REG_SPARE_HI, $urandom());
		send_pixel(10'd100, 10'd130);
		send_pixel(10'd200, 10'd60);
	endtask

	task automatic test_random_frames();
		cfg_t frame_cfg;
		int frame, n;
		for (frame = 0; frame < FRAMES; frame++) begin
			frame_cfg = '{origin_real: -(Q_ONE / 2), origin_imag: 0,
				step_size: 31'(Q_ONE >> 8), max_iterations: 16'd256,
				grid_width: 11'd1024, grid_height: 11'd1024};
			case (frame)
				1: begin
					frame_cfg.origin_real = -(3 * Q_ONE / 4);
					frame_cfg.origin_imag = Q_ONE / 10;
					frame_cfg.step_size = 31'(Q_ONE >> 12);
					frame_cfg.max_iterations = 16'd200;
				end
				2, 4: begin
					frame_cfg.origin_real = int'($urandom_range(0, 5 * Q_ONE / 2)) - 2 * Q_ONE;
					frame_cfg.origin_imag = int'($urandom_range(0, 5 * Q_ONE / 2))
						- 5 * Q_ONE / 4;
					frame_cfg.step_size = 31'($urandom_range(0, 1 << 22));
					frame_cfg.max_iterations = 16'($urandom_range(1, 64));
					frame_cfg.grid_width = 11'($urandom_range(0, 2047));
					frame_cfg.grid_height = 11'($urandom_range(0, 2047));
				end
				5: begin
					frame_cfg.step_size = 31'(Q_ONE >> 9);
					frame_cfg.max_iterations = 16'($urandom_range(64, 256));
				end
				6: frame_cfg.max_iterations = 16'd100;
				default: ;
			endcase
			if (frame == 3)
				write_random_regs();
			else
				load_config(frame_cfg);
			// last frame runs back to back on both sides
			if (frame == FRAMES - 1) begin
				gaps_on = 1'b0;
				stalls_on = 1'b0;
			end
			for (n = 0; n < PIXELS_PER_FRAME; n++) begin
				if (frame == 1 && n == PIXELS_PER_FRAME / 2)
					wait_drained();
				send_pixel(DIM_W'($urandom()), DIM_W'($urandom()));
			end
		end
	endtask

	// result stall process
	initial begin
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (stalls_on && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(negedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin : check_results
		escape_expect_t want;
		if (arst_n && out_valid === 1'b1 && out_ready === 1'b1) begin
			if (pending_escapes.size() == 0) begin
				report_mismatch($sformatf("escape_count %0d with no pending request",
					escape_count));
			end else begin
				want = pending_escapes.pop_front();
				if (escape_count !== want.rounds)
					report_mismatch($sformatf("pixel row %0d col %0d: escape_count %0d, want %0d",
						want.row, want.col, escape_count, want.rounds));
			end
		end
	end

	initial begin
		#(RUN_LIMIT);
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		model_cfg = '{origin_real: 0, origin_imag: 0, step_size: RST_STEP_SIZE,
			max_iterations: RST_MAX_ITER, grid_width: RST_GRID_WIDTH,
			grid_height: RST_GRID_HEIGHT};
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_reset_defaults();
		test_zero_round_limit();
		test_overflow_escape();
		test_grid_edges();
		test_long_orbit();
		test_unused_index();
		test_random_frames();
		wait_drained();
		repeat (20) @(negedge clk);
		if (mismatch_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

`default_nettype wire

[sim.f]
sv/mbet_pkg.sv
sv/mbet_regs.sv
sv/mbet_dp.sv
sv/mbet_ctrl.sv
sv/mandelbrot_escape_time_top.sv
tb/sv/tb.sv
